### design/csuq_pkg.sv
// Package for the count sketch update/query block: sizes, constants, helpers.
// Depends on nothing; used by count_sketch_update_query_top and its testbench.
package csuq_pkg;
    localparam int ROWS         = 5;
    localparam int BUCKETS      = 1024;
    localparam int COUNTER_BITS = 32;
    localparam int BKT_W        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W       = $clog2(ROWS * BUCKETS);
    localparam int DEPTH        = ROWS * BUCKETS;
    localparam int NUM_SEED_REGS = 5;
    localparam int CFG_IDX_W    = 3;
    localparam logic [63:0] MM_MUL = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] H_INIT = MM_MUL << 3; // 8 * MM_MUL, low 64 bits
    localparam logic [CFG_IDX_W-1:0] IDX_ROW0 = '0;

    typedef logic signed [COUNTER_BITS-1:0] t_cnt;

    localparam t_cnt CNT_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam t_cnt CNT_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    // Bucket index from the hash; power-of-two sizes reduce to a mask
    function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] h);
        logic [63:0] m;
        m = h % 64'(BUCKETS);
        return m[BKT_W-1:0];
    endfunction
endpackage

### design/csuq_ram.sv
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
module csuq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### design/count_sketch_update_query_top.sv
// Count sketch update/query top level: hash unit, counter RAM, median logic.
// Depends on csuq_pkg and csuq_ram.
//
// After reset the block sweeps the counter RAM to zero, one entry a cycle,
// and accepts no item meanwhile. Per row a multi-cycle MurmurHash unit with
// a single 32x32 multiplier computes the bucket and sign hashes (four 64-bit
// multiplies of three partial products each, one product a cycle), then the
// single-port counter RAM is read and, for an add, written back; the median
// over the rows is found by a sort at the end. The result sits in an output
// register; the next item is accepted only once that result is taken, at the
// earliest in the same cycle. A rejected item answers in the next cycle.
module count_sketch_update_query_top
    import csuq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [63:0]          i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [30:0]          o_estimate,
    output logic                 o_rejected
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HSTART = 4'd2,
                           S_HASH = 4'd3, S_READ = 4'd4, S_WAIT = 4'd5,
                           S_MOD = 4'd6, S_SORT = 4'd7, S_OUT = 4'd8;
    // hash micro-steps: k*=M, k^=k>>47, k*=M, h^=k,h*=M, h^=h>>47,h*=M, h^=h>>47
    localparam logic [2:0] H_K1 = 3'd0, H_K2 = 3'd1, H_H1 = 3'd2, H_H2 = 3'd3;

    logic [63:0] r_seeds [NUM_SEED_REGS];
    logic [3:0]  r_state;
    logic [ADDR_W-1:0] r_clr;
    logic        r_kind;
    logic [63:0] r_item;
    logic [ROW_W-1:0] r_row;
    logic        r_which;        // 0 bucket hash, 1 sign hash
    logic [2:0]  r_hstep;
    logic [1:0]  r_part;         // partial product index of a 64x64 low multiply
    logic [63:0] r_x, r_acc, r_h;
    logic [BKT_W-1:0] r_bkt;
    t_cnt        r_vals [ROWS];
    logic [ROW_W:0] r_si;
    logic        r_ovalid;
    logic [30:0] r_est;
    logic        r_rej;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    t_cnt              ram_wdata, ram_rdata;

    csuq_ram #(.WIDTH(COUNTER_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic [ADDR_W-1:0] row_addr;
    assign row_addr = ADDR_W'(r_row) * ADDR_W'(BUCKETS) + ADDR_W'(r_bkt);

    // Partial product of x * MM_MUL (low 64 bits) from three 32x32 products
    logic [31:0] pa, pb;
    logic [63:0] prod;
    always_comb begin
        case (r_part)
            2'd0:    begin pa = r_x[31:0];  pb = MM_MUL[31:0];  end
            2'd1:    begin pa = r_x[31:0];  pb = MM_MUL[63:32]; end
            default: begin pa = r_x[63:32]; pb = MM_MUL[31:0];  end
        endcase
        prod = 64'(pa) * 64'(pb);
    end
    logic [63:0] mul_next;
    always_comb begin
        case (r_part)
            2'd0:    mul_next = prod;
            default: mul_next = r_acc + {prod[31:0], 32'd0};
        endcase
    end

    // Counter update and signed view
    logic neg;
    t_cnt upd, signed_val;
    always_comb begin
        neg = ~r_h[0];
        upd = ram_rdata;
        if (neg) begin
            if (ram_rdata != CNT_MIN) upd = ram_rdata - t_cnt'(1);
        end else if (ram_rdata != CNT_MAX) begin
            upd = ram_rdata + t_cnt'(1);
        end
    end
    t_cnt cur;
    assign cur = r_kind ? ram_rdata : upd;
    assign signed_val = !neg ? cur : ((cur == CNT_MIN) ? CNT_MAX : -cur);

    // Odd-even transposition sort: one pass a cycle, ROWS passes
    t_cnt sorted [ROWS];
    always_comb begin
        for (int i = 0; i < ROWS; i++) sorted[i] = r_vals[i];
        for (int i = 0; i + 1 < ROWS; i++) begin
            if ((i % 2) == int'(r_si[0]) && r_vals[i] > r_vals[i+1]) begin
                sorted[i]   = r_vals[i+1];
                sorted[i+1] = r_vals[i];
            end
        end
    end
    t_cnt med;
    assign med = r_vals[ROWS/2];
    logic [30:0] med_clamp;
    always_comb begin
        if (med < 0) med_clamp = '0;
        else if (COUNTER_BITS > 32 && med > t_cnt'(32'h7fffffff)) med_clamp = '1;
        else med_clamp = 31'(med);
    end

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_estimate = r_est;
    assign o_rejected = r_rej;

    // Load the output register when a rejected item or a finished median is ready
    logic out_load;
    assign out_load = ((r_state == S_IDLE) && i_valid && o_ready && i_item[63])
                   || ((r_state == S_OUT) && (!r_ovalid || i_ready));

    always_comb begin
        ram_we = 1'b0;
        ram_addr = row_addr;
        ram_wdata = upd;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            ram_addr = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_MOD) begin
            ram_we = !r_kind;
        end
    end

    logic [63:0] seed_sel;
    assign seed_sel = r_seeds[r_row];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SEED_REGS; i++) r_seeds[i] <= '0;
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(NUM_SEED_REGS)) begin
            r_seeds[i_cfg_idx - IDX_ROW0] <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind <= i_kind;
                        r_item <= i_item;
                        if (i_item[63]) begin
                            r_est    <= '0;
                            r_rej    <= 1'b1;
                        end else begin
                            r_row   <= '0;
                            r_which <= 1'b0;
                            r_state <= S_HSTART;
                        end
                    end
                end
                S_HSTART: begin
                    r_x     <= r_item;
                    r_h     <= (r_which ? {32'd0, seed_sel[63:32]}
                                        : {32'd0, seed_sel[31:0]}) ^ H_INIT;
                    r_part  <= '0;
                    r_hstep <= H_K1;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    r_acc  <= mul_next;
                    r_part <= (r_part == 2'd2) ? 2'd0 : r_part + 2'd1;
                    if (r_part == 2'd2) begin
                        case (r_hstep)
                            H_K1: begin
                                r_x <= mul_next ^ (mul_next >> 47);
                                r_hstep <= H_K2;
                            end
                            H_K2: begin
                                r_x <= r_h ^ mul_next;
                                r_hstep <= H_H1;
                            end
                            H_H1: begin
                                r_x <= mul_next ^ (mul_next >> 47);
                                r_hstep <= H_H2;
                            end
                            default: begin
                                r_h <= mul_next ^ (mul_next >> 47);
                                if (!r_which) begin
                                    r_bkt   <= bucket_of(mul_next ^ (mul_next >> 47));
                                    r_which <= 1'b1;
                                    r_state <= S_HSTART;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                        endcase
                    end
                end
                S_READ:  r_state <= S_WAIT;
                S_WAIT:  r_state <= S_MOD;
                S_MOD: begin
                    r_vals[r_row] <= signed_val;
                    r_which <= 1'b0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        r_si    <= '0;
                        r_state <= S_SORT;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_HSTART;
                    end
                end
                S_SORT: begin
                    for (int i = 0; i < ROWS; i++) r_vals[i] <= sorted[i];
                    r_si <= r_si + 1'b1;
                    if (r_si == (ROW_W+1)'(ROWS - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_est    <= med_clamp;
                        r_rej    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready outside idle");
    a_ram_write_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_MOD))
        else $error("stray RAM write");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_estimate == '0))
        else $error("rejected item with estimate");
endmodule

### tb/count_sketch_update_query_top_tb.sv
// Testbench for count_sketch_update_query_top: directed and random add/estimate items.
// Depends on csuq_pkg and the RTL; predicts each result with its own sketch table model.
module count_sketch_update_query_top_tb;
    import csuq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_EST = 1'b1;
    localparam longint CYCLE_LIMIT = 1500000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_kind = 1'b0;
    logic [63:0]          i_item = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [30:0]          o_estimate;
    logic                 o_rejected;

    count_sketch_update_query_top DUT (.*);

    typedef struct packed {
        logic [30:0] estimate;
        logic        rejected;
    } t_answer;

    // Sketch state held by the predictor
    logic [63:0]  sk_seeds [NUM_SEED_REGS];
    logic signed [63:0] sk_table [ROWS][BUCKETS];
    t_answer      answers_due [$];
    int           n_errors = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           n_rejects = 0;
    longint       cycle_cnt = 0;
    bit           hold_off = 1'b0;
    logic [63:0]  hot_keys [16];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] murmur64(input logic [63:0] key, input logic [63:0] seed);
        logic [63:0] h, k;
        h = seed ^ H_INIT;
        k = key * MM_MUL;
        k = k ^ (k >> 47);
        k = k * MM_MUL;
        h = h ^ k;
        h = h * MM_MUL;
        h = h ^ (h >> 47);
        h = h * MM_MUL;
        h = h ^ (h >> 47);
        return h;
    endfunction

    function automatic int row_bucket(input int r, input logic [63:0] key);
        logic [63:0] hb;
        hb = murmur64(key, {32'd0, sk_seeds[r][31:0]});
        return int'(hb % 64'(BUCKETS));
    endfunction

    function automatic bit row_negative(input int r, input logic [63:0] key);
        logic [63:0] hs;
        hs = murmur64(key, {32'd0, sk_seeds[r][63:32]});
        return hs[0] == 1'b0;
    endfunction

    // Apply one item to the sketch and work out its answer
    function automatic t_answer sketch_apply(input logic kind, input logic [63:0] key);
        t_answer a;
        logic signed [63:0] v [ROWS];
        logic signed [63:0] c, t, m;
        int b, j;
        a = '0;
        if (key[63]) begin
            a.rejected = 1'b1;
            return a;
        end
        for (int r = 0; r < ROWS; r++) begin
            b = row_bucket(r, key);
            c = sk_table[r][b];
            if (kind == KIND_ADD) begin
                if (row_negative(r, key)) begin
                    if (c > 64'(CNT_MIN)) c = c - 1;
                end else begin
                    if (c < 64'(CNT_MAX)) c = c + 1;
                end
                sk_table[r][b] = c;
            end
            v[r] = row_negative(r, key) ? -c : c;
        end
        // Insertion sort, upper median
        for (int i = 1; i < ROWS; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        m = v[ROWS/2];
        if (m < 0) m = 0;
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        a.estimate = m[30:0];
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_cnt);
    endtask

    // Receiver: random stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 7) < 2) ? 1'b0 : ($urandom_range(0, 3) != 0 || 1'b1);
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", {32'd0, o_estimate, o_rejected}, '0);
            end else begin
                want = answers_due.pop_front();
                if (o_estimate !== want.estimate)
                    report_mismatch("estimate", 64'(o_estimate), 64'(want.estimate));
                if (o_rejected !== want.rejected)
                    report_mismatch("rejected", 64'(o_rejected), 64'(want.rejected));
            end
        end
    end

    // Send one item; bursts with random gaps between them. Valid stays up
    // after acceptance until the next item or an explicit drop.
    task automatic send_item(input logic kind, input logic [63:0] key);
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_item  <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        answers_due.push_back(sketch_apply(kind, key));
        n_items++;
        if (key[63]) n_rejects++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_seed(input int idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_SEED_REGS) sk_seeds[idx] = val;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Key mostly from a small hot set so counters grow and collide
    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 9))
            0: return rand64();
            1: return rand64() & 64'h7fff_ffff_ffff_ffff;
            default: return hot_keys[$urandom_range(0, 15)];
        endcase
    endfunction

    task automatic test_directed();
        send_item(KIND_EST, 64'd0);
        send_item(KIND_ADD, 64'd0);
        send_item(KIND_ADD, 64'd0);
        send_item(KIND_EST, 64'd0);
        send_item(KIND_ADD, 64'h7fff_ffff_ffff_ffff);
        send_item(KIND_EST, 64'h7fff_ffff_ffff_ffff);
        send_item(KIND_ADD, 64'h8000_0000_0000_0000);
        send_item(KIND_EST, 64'hffff_ffff_ffff_ffff);
        send_item(KIND_ADD, 64'hffff_ffff_ffff_ffff);
        send_item(KIND_EST, 64'h8000_0000_0000_0000);
        send_item(KIND_ADD, 64'h5555_5555_5555_5555);
        send_item(KIND_ADD, 64'h2aaa_aaaa_aaaa_aaaa);
        send_item(KIND_EST, 64'h5555_5555_5555_5555);
        send_item(KIND_EST, 64'd1);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_item(($urandom_range(0, 2) == 0) ? KIND_EST : KIND_ADD, pick_key());
    endtask

    // Long receiver hold-off while items keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
    endtask

    task automatic test_seed_settings();
        int i;
        // Extremes, then random settings; out-of-range index is ignored
        for (i = 0; i < NUM_SEED_REGS; i++) write_seed(i, '1);
        write_seed(NUM_SEED_REGS, rand64());
        write_seed(7, rand64());
        test_random(400);
        wait_drained();
        for (i = 0; i < NUM_SEED_REGS; i++) write_seed(i, rand64());
        test_random(500);
        wait_drained();
        for (i = 0; i < NUM_SEED_REGS; i++)
            write_seed(i, {32'hffff_ffff * (i % 2), 32'(i * 3)});
        test_random(500);
    endtask

    initial begin
        for (int r = 0; r < NUM_SEED_REGS; r++) sk_seeds[r] = '0;
        for (int r = 0; r < ROWS; r++)
            for (int b = 0; b < BUCKETS; b++) sk_table[r][b] = '0;
        for (int k = 0; k < 16; k++) hot_keys[k] = rand64() & 64'h7fff_ffff_ffff_ffff;
        hot_keys[0] = 64'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        for (int i = 0; i < NUM_SEED_REGS; i++) write_seed(i, 64'h0123_4567_89ab_cdef + i);
        test_random(500);
        test_backpressure();
        wait_drained();
        test_seed_settings();
        wait_drained();
        $display("covered %0d items (%0d rejected keys), %0d results checked",
                 n_items, n_rejects, n_results);
        $display("seed settings: reset, all-ones, random, patterned; one long output stall");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
